// ----- rtl/sml_pkg.sv -----
`default_nettype none

package sml_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int REG_BYTES       = 16;
    localparam int LEN_W           = 5;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 64;
    localparam logic [15:0] SAT16  = 16'hFFFF;

    localparam logic [1:0] REG_PAT_LO  = 2'd0;
    localparam logic [1:0] REG_PAT_HI  = 2'd1;
    localparam logic [1:0] REG_PAT_LEN = 2'd2;
    localparam logic [1:0] REG_CASE    = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       string_end;
    } text_in_t;

    typedef struct packed {
        logic [15:0] result_slot;
        logic [15:0] start_position;
        logic [15:0] match_count;
    } result_t;

    // pattern laid out against the window: entry j meets window entry j
    typedef struct packed {
        logic [REG_BYTES-1:0][7:0] pat;
        logic [REG_BYTES-1:0]      mask;
        logic [LEN_W-1:0]          len;
        logic                      exact;
    } align_t;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic exact);
        logic [7:0] r;
        r = c;
        if (!exact && c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == SAT16) ? SAT16 : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sml_cfg.sv -----
`default_nettype none

module sml_cfg #(
    parameter int PATTERN_MAX = sml_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sml_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [sml_pkg::DATA_W-1:0]      pwdata,
    output logic      [sml_pkg::DATA_W-1:0]      prdata,
    output logic                                 pready,
    output sml_pkg::align_t                      align
);

    localparam int EFF = (PATTERN_MAX < sml_pkg::REG_BYTES) ? PATTERN_MAX
                                                            : sml_pkg::REG_BYTES;

    logic [63:0]                   pat_lo_reg;
    logic [63:0]                   pat_hi_reg;
    logic [sml_pkg::LEN_W-1:0]     pat_len_reg;
    logic                          case_reg;
    sml_pkg::align_t               align_reg;
    sml_pkg::align_t               align_next;
    logic                          wr;
    logic [1:0]                    idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= '0;
            case_reg    <= 1'b1;
        end
        else if (wr)
        begin
            unique case (idx)
                sml_pkg::REG_PAT_LO:  pat_lo_reg  <= pwdata;
                sml_pkg::REG_PAT_HI:  pat_hi_reg  <= pwdata;
                sml_pkg::REG_PAT_LEN: pat_len_reg <= pwdata[sml_pkg::LEN_W-1:0];
                sml_pkg::REG_CASE:    case_reg    <= pwdata[0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            sml_pkg::REG_PAT_LO:  prdata = pat_lo_reg;
            sml_pkg::REG_PAT_HI:  prdata = pat_hi_reg;
            sml_pkg::REG_PAT_LEN: prdata = {{(sml_pkg::DATA_W-sml_pkg::LEN_W){1'b0}},
                                            pat_len_reg};
            sml_pkg::REG_CASE:    prdata = {{(sml_pkg::DATA_W-1){1'b0}}, case_reg};
            default:              prdata = '0;
        endcase
    end

    // reverse and fold the pattern once, ahead of the byte compare
    always_comb
    begin
        logic [sml_pkg::REG_BYTES-1:0][7:0] pat_all;
        logic [sml_pkg::LEN_W-1:0]          len_eff;
        logic [3:0]                         src;
        pat_all = {pat_hi_reg, pat_lo_reg};
        len_eff = (pat_len_reg > sml_pkg::LEN_W'(EFF)) ? sml_pkg::LEN_W'(EFF) : pat_len_reg;
        align_next       = '0;
        align_next.len   = len_eff;
        align_next.exact = case_reg;
        for (int j = 0; j < EFF; j++)
        begin
            src = 4'(len_eff - sml_pkg::LEN_W'(j) - sml_pkg::LEN_W'(1));
            if (sml_pkg::LEN_W'(j) < len_eff)
            begin
                align_next.pat[j]  = sml_pkg::fold(pat_all[src], case_reg);
                align_next.mask[j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_reg <= '0;
        end
        else
        begin
            align_reg <= align_next;
        end
    end

    assign align = align_reg;

endmodule

`default_nettype wire

// ----- rtl/sml_cmp.sv -----
`default_nettype none

module sml_cmp #(
    parameter int PATTERN_MAX = sml_pkg::PATTERN_MAX_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire sml_pkg::text_in_t text,
    input  wire sml_pkg::align_t  align,
    output logic                  bytes_equal
);

    localparam int EFF = (PATTERN_MAX < sml_pkg::REG_BYTES) ? PATTERN_MAX
                                                            : sml_pkg::REG_BYTES;

    // entry 0 is the newest byte
    logic [EFF-1:0][7:0] window_reg;
    logic [EFF-1:0][7:0] window_next;

    always_comb
    begin
        window_next[0] = text.text_byte;
        for (int j = 1; j < EFF; j++)
        begin
            window_next[j] = window_reg[j-1];
        end
    end

    always_comb
    begin
        bytes_equal = 1'b1;
        for (int j = 0; j < EFF; j++)
        begin
            if (align.mask[j] &&
                sml_pkg::fold(window_next[j], align.exact) != align.pat[j])
            begin
                bytes_equal = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (step)
        begin
            window_reg <= text.string_end ? '0 : window_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sml_ctr.sv -----
`default_nettype none

module sml_ctr (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic                          string_end,
    input  wire logic                          bytes_equal,
    input  wire logic [sml_pkg::LEN_W-1:0]     len,
    output logic                               hit,
    output sml_pkg::result_t                   result
);

    logic [15:0] pos_reg;
    logic        has_match_reg;
    logic [15:0] count_reg;
    logic [15:0] slots_reg;
    logic [15:0] cur_slot_reg;

    assign hit = bytes_equal &&
                 ({1'b0, pos_reg} + 17'd1 >= {{(17-sml_pkg::LEN_W){1'b0}}, len});

    always_comb
    begin
        result.result_slot = has_match_reg ? cur_slot_reg : slots_reg;
        result.match_count = sml_pkg::sat_inc(count_reg);
        if (len == '0)
        begin
            result.start_position = pos_reg;
        end
        else if (pos_reg == sml_pkg::SAT16)
        begin
            result.start_position = sml_pkg::SAT16;
        end
        else
        begin
            result.start_position = pos_reg + 16'd1 - {{(16-sml_pkg::LEN_W){1'b0}}, len};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            has_match_reg <= 1'b0;
            count_reg     <= '0;
            slots_reg     <= '0;
            cur_slot_reg  <= '0;
        end
        else if (step)
        begin
            if (hit && !has_match_reg)
            begin
                cur_slot_reg <= slots_reg;
                slots_reg    <= sml_pkg::sat_inc(slots_reg);
            end
            if (string_end)
            begin
                pos_reg       <= '0;
                has_match_reg <= 1'b0;
                count_reg     <= '0;
            end
            else
            begin
                pos_reg <= sml_pkg::sat_inc(pos_reg);
                if (hit)
                begin
                    has_match_reg <= 1'b1;
                    count_reg     <= sml_pkg::sat_inc(count_reg);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/substring_match_locator.sv -----
// Substring match locator.
// Text channel: text_valid / text_stall carry one byte per transfer with a
// string_end flag on the last byte of each string. Result channel:
// result_valid / result_stall carry slot, start position and running count
// of each match, at most one result per text byte.
// The pattern, its length and the case mode are written through the APB
// port (64-bit registers at byte addresses 0, 8, 16, 24); the user must
// write them only while the block is idle, as the block does not enforce
// this. pready is always high. An accepted byte is held in the input
// register, and its result is registered once the result register can advance.
// Throughput: one byte per cycle while no result is stalled; the window
// compare is a single parallel stage between the input register and the
// result register. Reset clears the window, all counters and the registers
// (case_reg comes up as exact compare); no clearing pass is needed.
// While result_stall holds a result, one more byte is taken into the input
// register, after which text_stall rises until the result is taken.
`default_nettype none

module substring_match_locator #(
    parameter int PATTERN_MAX = sml_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sml_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [sml_pkg::DATA_W-1:0]    pwdata,
    output logic      [sml_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          text_valid,
    output logic                               text_stall,
    input  wire sml_pkg::text_in_t             text,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output sml_pkg::result_t                   result
);

    sml_pkg::align_t    align;
    logic               in_valid_reg;
    logic               in_valid_next;
    sml_pkg::text_in_t  in_data_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    sml_pkg::result_t   out_data_reg;
    sml_pkg::result_t   res;
    logic               advance;
    logic               step;
    logic               accept;
    logic               bytes_equal;
    logic               hit;

    assign advance    = !out_valid_reg || !result_stall;
    assign step       = in_valid_reg && advance;
    assign text_stall = in_valid_reg && !advance;
    assign accept     = text_valid && !text_stall;

    sml_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .align   (align)
    );

    sml_cmp #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cmp (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .text        (in_data_reg),
        .align       (align),
        .bytes_equal (bytes_equal)
    );

    sml_ctr u_ctr (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .string_end  (in_data_reg.string_end),
        .bytes_equal (bytes_equal),
        .len         (align.len),
        .hit         (hit),
        .result      (res)
    );

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
        out_valid_next = advance ? (step && hit) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= text;
        end
        if (step && hit)
        begin
            out_data_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

`default_nettype wire

// ----- tb/sv/substring_match_locator_tb.sv -----
`default_nettype none

module substring_match_locator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW  = sml_pkg::PATTERN_MAX_DEF;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [sml_pkg::ADDR_W-1:0] paddr;
    logic [sml_pkg::DATA_W-1:0] pwdata;
    logic [sml_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       text_valid;
    logic                       text_stall;
    sml_pkg::text_in_t          text;
    logic                       result_valid;
    logic                       result_stall;
    sml_pkg::result_t           result;

    int gap_pct    = 0;
    int stall_pct  = 0;
    int mismatches = 0;
    int bytes_sent = 0;

    // register mirror
    logic [63:0] pat_lo  = '0;
    logic [63:0] pat_hi  = '0;
    logic [4:0]  pat_len = '0;
    logic        exact   = 1'b1;

    // locator state
    logic [7:0]  window [WINDOW];
    logic [15:0] pos         = '0;
    logic        string_hit  = 1'b0;
    logic [15:0] str_matches = '0;
    logic [15:0] slots_used  = '0;
    logic [15:0] slot        = '0;
    sml_pkg::result_t pending_matches [$];

    substring_match_locator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text         (text),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pattern_span();
        int n;
        n = pat_len;
        if (n > WINDOW)
            n = WINDOW;
        if (n > sml_pkg::REG_BYTES)
            n = sml_pkg::REG_BYTES;
        return n;
    endfunction

    function automatic logic [7:0] pattern_at(input int k);
        logic [127:0] both;
        both = {pat_hi, pat_lo};
        return both[8*k +: 8];
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (!exact && c >= 8'h61 && c <= 8'h7A)
            return c & 8'hDF;
        return c;
    endfunction

    function automatic logic [7:0] swap_case(input logic [7:0] c);
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
            return c ^ 8'h20;
        return c;
    endfunction

    function automatic logic [15:0] bump(input logic [15:0] v);
        if (&v)
            return v;
        return v + 16'd1;
    endfunction

    function automatic void locate_match(input sml_pkg::text_in_t item);
        int               span;
        int               k;
        logic             hit;
        logic [15:0]      start;
        sml_pkg::result_t r;
        span = pattern_span();
        for (k = WINDOW - 1; k > 0; k--)
            window[k] = window[k-1];
        window[0] = item.text_byte;
        hit = (int'(pos) + 1 >= span);
        for (k = 0; k < span; k++)
            if (upcase(pattern_at(k)) != upcase(window[span-1-k]))
                hit = 1'b0;
        if (hit)
        begin
            if (span == 0)
                start = pos;
            else if (&pos)
                start = 16'hFFFF;
            else
                start = pos + 16'd1 - 16'(span);
            if (!string_hit)
            begin
                string_hit = 1'b1;
                slot       = slots_used;
                slots_used = bump(slots_used);
            end
            str_matches = bump(str_matches);
            r.result_slot    = slot;
            r.start_position = start;
            r.match_count    = str_matches;
            pending_matches.push_back(r);
        end
        if (item.string_end)
        begin
            pos         = '0;
            string_hit  = 1'b0;
            str_matches = '0;
            for (k = 0; k < WINDOW; k++)
                window[k] = 8'h00;
        end
        else
            pos = bump(pos);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : monitor
        sml_pkg::result_t want;
        if (rst_n)
        begin
            if (text_valid && !text_stall)
                locate_match(text);
            if (result_valid && !result_stall)
            begin
                if (pending_matches.size() == 0)
                    flag_mismatch($sformatf("unexpected result %h", result));
                else
                begin
                    want = pending_matches.pop_front();
                    if (result.result_slot !== want.result_slot)
                        flag_mismatch($sformatf("result_slot %h, want %h",
                                                result.result_slot, want.result_slot));
                    if (result.start_position !== want.start_position)
                        flag_mismatch($sformatf("start_position %h, want %h",
                                                result.start_position, want.start_position));
                    if (result.match_count !== want.match_count)
                        flag_mismatch($sformatf("match_count %h, want %h",
                                                result.match_count, want.match_count));
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sml_pkg::REG_PAT_LO:  pat_lo  = value;
            sml_pkg::REG_PAT_HI:  pat_hi  = value;
            sml_pkg::REG_PAT_LEN: pat_len = value[4:0];
            sml_pkg::REG_CASE:    exact   = value[0];
        endcase
    endtask

    // valid stays high after the transfer; the caller either follows on or idles
    task automatic send_text(input logic [7:0] c, input logic last);
        sml_pkg::text_in_t item;
        while ($urandom_range(99) < gap_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        // zero is not a legal text character
        item.text_byte  = (c == 8'h00) ? 8'hFF : c;
        item.string_end = last;
        text_valid <= 1'b1;
        text       <= item;
        do
            @(posedge clk);
        while (text_stall);
        bytes_sent++;
    endtask

    task automatic wait_for_results();
        text_valid <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_for_results();
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random_string();
        int         n;
        int         k;
        int         j;
        int         span;
        int         cut;
        int         choice;
        logic [7:0] c;
        span = pattern_span();
        n = ($urandom_range(9) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24);
        k = 0;
        while (k < n)
        begin
            choice = $urandom_range(99);
            if (span > 0 && choice < 40)
            begin
                // whole pattern, sometimes a broken prefix
                cut = ($urandom_range(3) == 0) ? $urandom_range(span, 1) : span;
                for (j = 0; j < cut && k < n; j++)
                begin
                    c = pattern_at(j);
                    if (!exact && $urandom_range(1) == 1)
                        c = swap_case(c);
                    send_text(c, k == n - 1);
                    k++;
                end
            end
            else
            begin
                if (span > 0 && choice < 75)
                    c = pattern_at($urandom_range(span - 1));
                else
                    c = 8'($urandom_range(255, 1));
                send_text(c, k == n - 1);
                k++;
            end
        end
    endtask

    task automatic load_random_config(input int phase, input int step);
        logic [127:0] word;
        logic [7:0]   c;
        int           k;
        int           style;
        int           span;
        style = $urandom_range(2);
        for (k = 0; k < 16; k++)
        begin
            case (style)
                0:       c = 8'h61 + 8'($urandom_range(1));
                1:       c = 8'h61 + 8'($urandom_range(25));
                default: c = 8'($urandom_range(255));
            endcase
            if (style != 2 && $urandom_range(1) == 1)
                c = swap_case(c);
            word[8*k +: 8] = c;
        end
        if (step == 0)
        begin
            case (phase)
                0:       span = 0;
                1:       span = 16;
                2:       span = 31;
                default: span = 1;
            endcase
        end
        else if ($urandom_range(3) == 0)
            span = $urandom_range(20, 7);
        else
            span = $urandom_range(6, 1);
        write_reg(sml_pkg::REG_PAT_LO, word[63:0]);
        write_reg(sml_pkg::REG_PAT_HI, word[127:64]);
        write_reg(sml_pkg::REG_PAT_LEN, 64'(span));
        write_reg(sml_pkg::REG_CASE, 64'($urandom_range(1)));
    endtask

    task automatic test_empty_pattern();
        settle();
        write_reg(sml_pkg::REG_PAT_LEN, 64'd0);
        write_reg(sml_pkg::REG_CASE, 64'd1);
        send_text(8'h01, 1'b0);
        send_text(8'hFF, 1'b1);
    endtask

    task automatic test_case_fold();
        settle();
        write_reg(sml_pkg::REG_PAT_LO, 64'h6241);
        write_reg(sml_pkg::REG_PAT_LEN, 64'd2);
        write_reg(sml_pkg::REG_CASE, 64'd0);
        send_text(8'h78, 1'b0);
        send_text(8'h41, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b1);
    endtask

    task automatic test_short_string();
        settle();
        write_reg(sml_pkg::REG_PAT_LO, 64'h636241);
        write_reg(sml_pkg::REG_PAT_LEN, 64'd3);
        write_reg(sml_pkg::REG_CASE, 64'd1);
        send_text(8'h41, 1'b0);
        send_text(8'h62, 1'b1);
    endtask

    // length above the window is cut to 16; letters sent with case swapped
    task automatic test_long_pattern();
        logic [127:0] word;
        int           k;
        word = {64'h6B7B_605B_4020_417A, 64'h807E_516D_5A61_FF01};
        settle();
        write_reg(sml_pkg::REG_PAT_LO, word[63:0]);
        write_reg(sml_pkg::REG_PAT_HI, word[127:64]);
        write_reg(sml_pkg::REG_PAT_LEN, 64'd31);
        write_reg(sml_pkg::REG_CASE, 64'd0);
        for (k = 0; k < 16; k++)
            send_text(swap_case(word[8*k +: 8]), k == 15);
    endtask

    task automatic test_random_traffic();
        int phase;
        int step;
        int quota;
        for (phase = 0; phase < 4; phase++)
        begin
            for (step = 0; step < 4; step++)
            begin
                settle();
                case (phase)
                    0:       begin gap_pct = 0;  stall_pct = 0;  end
                    1:       begin gap_pct = 54; stall_pct = 0;  end
                    2:       begin gap_pct = 0;  stall_pct = 54; end
                    default: begin gap_pct = 16; stall_pct = 16; end
                endcase
                load_random_config(phase, step);
                quota = bytes_sent + 23;
                while (bytes_sent < quota)
                    send_random_string();
                if (step == 1)
                    wait_for_results();
                quota = bytes_sent + 23;
                while (bytes_sent < quota)
                    send_random_string();
            end
        end
    endtask

    initial
    begin : main
        int k;
        for (k = 0; k < WINDOW; k++)
            window[k] = 8'h00;
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        text_valid <= 1'b0;
        text       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_pattern();
        test_case_fold();
        test_short_string();
        test_long_pattern();
        test_random_traffic();
        settle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/sml_pkg.sv
rtl/sml_cfg.sv
rtl/sml_cmp.sv
rtl/sml_ctr.sv
rtl/substring_match_locator.sv
tb/sv/substring_match_locator_tb.sv
